// ===== design/tss_pkg.sv =====
// Package for the 2-SAT solver: opcodes, FSM states, command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package tss_pkg;
	localparam int LitCount = 64;
	localparam int MaxVars = 32;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SOLVE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_VAR,
		ST_PROP,
		ST_WALK,
		ST_POP,
		ST_UNDO,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic add_edge;
		logic var_init;
		logic var_next;
		logic prop_start;
		logic walk_step;
		logic pop_load;
		logic undo_step;
		logic try_neg;
		logic set_result;
		logic result_val;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic vars_done;
		logic var_marked;
		logic prop_conflict;
		logic prop_skip;
		logic walk_conflict;
		logic walk_done;
		logic walk_pop;
		logic undo_done;
		logic on_neg;
	} status_t;
endpackage

// ===== design/tss_if.sv =====
// Valid/ready channel interfaces for the 2-SAT solver.
// Depends on nothing.
`timescale 1ns / 1ps
interface tss_in_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [5:0] from_literal;
	logic [5:0] to_literal;
	modport source(output valid, opcode, from_literal, to_literal, input ready);
	modport sink(input valid, opcode, from_literal, to_literal, output ready);
endinterface

interface tss_out_if;
	logic valid;
	logic ready;
	logic satisfiable;
	modport source(output valid, satisfiable, input ready);
	modport sink(input valid, satisfiable, output ready);
endinterface

// ===== design/tss_datapath.sv =====
// Datapath: adjacency memory, marks, trail and walk stacks, variable counter.
// Depends on tss_pkg.
`timescale 1ns / 1ps
module tss_datapath (
	input logic clk,
	input logic arst_n,
	input tss_pkg::cmd_t cmd,
	input logic [5:0] from_literal,
	input logic [5:0] to_literal,
	input logic [5:0] var_count,
	output tss_pkg::status_t status,
	output logic satisfiable
);
	logic [63:0] adj_mem [64];
	logic [63:0] row_q;
	logic [63:0] marks_q;
	logic [5:0] trail_mem [64];
	logic [6:0] trail_cnt_q;
	logic [5:0] wlit_mem [64];
	logic [6:0] wnext_mem [64];
	logic [6:0] wdepth_q;
	logic [5:0] top_lit_q;
	logic [6:0] top_next_q;
	logic [5:0] pop_lit_q;
	logic [6:0] pop_next_q;
	logic [5:0] undo_lit_q;
	logic undo_pend_q;
	logic [5:0] clr_q;
	logic [5:0] var_q;
	logic neg_q;
	logic sat_q;
	logic [5:0] n_vars;
	logic [5:0] pos_lit;
	logic [5:0] try_lit;
	logic [63:0] masked;
	logic found;
	logic [5:0] succ;
	logic [6:0] dm1;
	logic push_new;

	assign n_vars = (var_count > 6'(tss_pkg::MaxVars)) ? 6'(tss_pkg::MaxVars) : var_count;
	assign pos_lit = {var_q[4:0], 1'b0};
	assign try_lit = {var_q[4:0], neg_q};
	assign dm1 = wdepth_q - 7'd1;
	assign push_new = cmd.walk_step & found & ~marks_q[succ ^ 6'd1] & ~marks_q[succ] &
		~wdepth_q[6];

	always_comb begin
		masked = row_q & ~((64'd1 << top_next_q[5:0]) - 64'd1);
		if (top_next_q[6]) masked = '0;
		found = 1'b0;
		succ = '0;
		for (int i = 63; i >= 0; i--) begin
			if (masked[i]) begin
				found = 1'b1;
				succ = 6'(i);
			end
		end
	end

	always_comb begin
		status.clear_done = (clr_q == 6'd63);
		status.vars_done = ({1'b0, var_q} >= {1'b0, n_vars});
		status.var_marked = marks_q[pos_lit] | marks_q[pos_lit | 6'd1];
		status.prop_conflict = marks_q[try_lit ^ 6'd1];
		status.prop_skip = marks_q[try_lit];
		status.walk_conflict = found & marks_q[succ ^ 6'd1];
		status.walk_done = ~found & (wdepth_q == 7'd1);
		status.walk_pop = ~found;
		status.undo_done = (trail_cnt_q == 7'd0);
		status.on_neg = neg_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.add_edge) adj_mem[from_literal][to_literal] <= 1'b1;
		else if (cmd.clear_step) adj_mem[clr_q] <= '0;
		if (cmd.prop_start) row_q <= adj_mem[try_lit];
		else if (cmd.pop_load) row_q <= adj_mem[pop_lit_q];
		else if (push_new) row_q <= adj_mem[succ];
	end

	always_ff @(posedge clk) begin
		if (cmd.prop_start) begin
			trail_mem[trail_cnt_q[5:0]] <= try_lit;
			wlit_mem[0] <= try_lit;
			wnext_mem[0] <= '0;
		end else if (cmd.walk_step && found) begin
			wnext_mem[dm1[5:0]] <= {1'b0, succ} + 7'd1;
			if (!marks_q[succ]) begin
				if (!trail_cnt_q[6]) trail_mem[trail_cnt_q[5:0]] <= succ;
				if (!wdepth_q[6]) begin
					wlit_mem[wdepth_q[5:0]] <= succ;
					wnext_mem[wdepth_q[5:0]] <= '0;
				end
			end
		end
		if (cmd.walk_step && !found) begin
			pop_lit_q <= wlit_mem[6'(dm1 - 7'd1)];
			pop_next_q <= wnext_mem[6'(dm1 - 7'd1)];
		end
		if (cmd.undo_step) undo_lit_q <= trail_mem[6'(trail_cnt_q - 7'd1)];
	end

	// top_lit_q/top_next_q mirror the stack top so the scan needs no memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
			trail_cnt_q <= '0;
			wdepth_q <= '0;
			clr_q <= '0;
			var_q <= '0;
			neg_q <= 1'b0;
			sat_q <= 1'b0;
			top_lit_q <= '0;
			top_next_q <= '0;
			undo_pend_q <= 1'b0;
		end else begin
			if (undo_pend_q) marks_q[undo_lit_q] <= 1'b0;
			if (cmd.clear_step) begin
				clr_q <= clr_q + 6'd1;
				marks_q <= '0;
				trail_cnt_q <= '0;
				wdepth_q <= '0;
			end
			if (cmd.var_init) begin
				var_q <= '0;
				neg_q <= 1'b0;
				trail_cnt_q <= '0;
			end
			if (cmd.var_next) begin
				var_q <= var_q + 6'd1;
				neg_q <= 1'b0;
				trail_cnt_q <= '0;
			end
			if (cmd.try_neg) neg_q <= 1'b1;
			if (cmd.prop_start) begin
				marks_q[try_lit] <= 1'b1;
				if (!trail_cnt_q[6]) trail_cnt_q <= trail_cnt_q + 7'd1;
				wdepth_q <= 7'd1;
				top_lit_q <= try_lit;
				top_next_q <= '0;
			end
			if (cmd.walk_step) begin
				if (!found) begin
					wdepth_q <= dm1;
				end else if (marks_q[succ ^ 6'd1]) begin
					wdepth_q <= '0;
				end else if (!marks_q[succ]) begin
					marks_q[succ] <= 1'b1;
					if (!trail_cnt_q[6]) trail_cnt_q <= trail_cnt_q + 7'd1;
					if (!wdepth_q[6]) begin
						wdepth_q <= wdepth_q + 7'd1;
						top_lit_q <= succ;
						top_next_q <= '0;
					end else top_next_q <= {1'b0, succ} + 7'd1;
				end else begin
					top_next_q <= {1'b0, succ} + 7'd1;
				end
			end
			if (cmd.pop_load) begin
				top_lit_q <= pop_lit_q;
				top_next_q <= pop_next_q;
			end
			if (cmd.undo_step) begin
				undo_pend_q <= (trail_cnt_q != 7'd0);
				if (trail_cnt_q != 7'd0) trail_cnt_q <= trail_cnt_q - 7'd1;
			end
			if (cmd.set_result) sat_q <= cmd.result_val;
		end
	end

	assign satisfiable = sat_q;
endmodule

// ===== design/tss_ctrl.sv =====
// Controller FSM sequencing clear, add and solve.
// Depends on tss_pkg.
`timescale 1ns / 1ps
module tss_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] opcode,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input tss_pkg::status_t status,
	output tss_pkg::cmd_t cmd
);
	tss_pkg::state_t state_q, state_d;
	logic acc;

	assign acc = in_valid & in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tss_pkg::ST_IDLE: begin
				if (acc && opcode == tss_pkg::OP_CLEAR) state_d = tss_pkg::ST_CLEAR;
				else if (acc && opcode == tss_pkg::OP_SOLVE) state_d = tss_pkg::ST_VAR;
			end
			tss_pkg::ST_CLEAR: if (status.clear_done) state_d = tss_pkg::ST_IDLE;
			tss_pkg::ST_VAR: begin
				if (status.vars_done) state_d = tss_pkg::ST_RESULT;
				else if (!status.var_marked) state_d = tss_pkg::ST_PROP;
			end
			tss_pkg::ST_PROP: begin
				if (status.prop_conflict)
					state_d = status.on_neg ? tss_pkg::ST_RESULT : tss_pkg::ST_UNDO;
				else if (status.prop_skip) state_d = tss_pkg::ST_VAR;
				else state_d = tss_pkg::ST_WALK;
			end
			tss_pkg::ST_WALK: begin
				if (status.walk_conflict)
					state_d = status.on_neg ? tss_pkg::ST_RESULT : tss_pkg::ST_UNDO;
				else if (status.walk_done) state_d = tss_pkg::ST_VAR;
				else if (status.walk_pop) state_d = tss_pkg::ST_POP;
			end
			tss_pkg::ST_POP: state_d = tss_pkg::ST_WALK;
			tss_pkg::ST_UNDO: if (status.undo_done) state_d = tss_pkg::ST_PROP;
			tss_pkg::ST_RESULT: if (out_ready) state_d = tss_pkg::ST_IDLE;
			default: state_d = tss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = (state_q == tss_pkg::ST_IDLE);
		out_valid = 1'b0;
		case (state_q)
			tss_pkg::ST_IDLE: begin
				cmd.add_edge = acc && opcode == tss_pkg::OP_ADD;
				cmd.clear_step = acc && opcode == tss_pkg::OP_CLEAR;
				cmd.var_init = acc && opcode == tss_pkg::OP_SOLVE;
			end
			tss_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			tss_pkg::ST_VAR: begin
				if (status.vars_done) begin
					cmd.set_result = 1'b1;
					cmd.result_val = 1'b1;
				end else if (status.var_marked) cmd.var_next = 1'b1;
			end
			tss_pkg::ST_PROP: begin
				if (status.prop_conflict) begin
					cmd.set_result = status.on_neg;
					cmd.try_neg = 1'b1;
				end else if (status.prop_skip) cmd.var_next = 1'b1;
				else cmd.prop_start = 1'b1;
			end
			tss_pkg::ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (status.walk_conflict) begin
					cmd.set_result = status.on_neg;
					cmd.try_neg = 1'b1;
				end else if (status.walk_done) cmd.var_next = 1'b1;
			end
			tss_pkg::ST_POP: cmd.pop_load = 1'b1;
			tss_pkg::ST_UNDO: cmd.undo_step = 1'b1;
			tss_pkg::ST_RESULT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tss_pkg::ST_CLEAR;
		else state_q <= state_d;
	end
endmodule

// ===== design/two_sat_solver_core.sv =====
// Top level of the 2-SAT solver: controller plus datapath.
// Depends on tss_pkg, tss_if, tss_ctrl, tss_datapath.
`timescale 1ns / 1ps
// A clear sweeps the adjacency memory one row per cycle; the same sweep runs
// after reset before the first beat is accepted. A solve checks each variable,
// starts each try, follows each successor found, pops literals off the walk
// stack and undoes marks, and holds the input until its result beat is taken.
module two_sat_solver_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [5:0] cfg_wdata,
	tss_in_if.sink in_ch,
	tss_out_if.source out_ch
);
	tss_pkg::cmd_t cmd;
	tss_pkg::status_t status;
	logic [5:0] var_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) var_count_q <= '0;
		else if (cfg_we) var_count_q <= cfg_wdata;
	end

	tss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .opcode(in_ch.opcode),
		.in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.status(status), .cmd(cmd)
	);

	tss_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .from_literal(in_ch.from_literal),
		.to_literal(in_ch.to_literal), .var_count(var_count_q), .status(status),
		.satisfiable(out_ch.satisfiable)
	);

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("in and out both open");
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.add_edge, cmd.walk_step, cmd.undo_step, cmd.prop_start}))
		else $error("conflicting commands");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.satisfiable))
		else $error("result dropped");
endmodule

// ===== tb/tb_top.sv =====
// Testbench for two_sat_solver_core: directed and random add/solve/clear beats
// checked against an in-bench implication-graph solver. Depends on tss_pkg, tss_if.
`timescale 1ns / 1ps
module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [5:0] cfg_wdata = 0;

	tss_in_if in_ch();
	tss_out_if out_ch();

	two_sat_solver_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [63:0] graph [64];
	logic [63:0] marks;
	logic [5:0] trail [64];
	int trail_n;
	logic [12:0] walk [64];
	int walk_n;
	int nvars;

	logic sat_q [$];
	int errors = 0;
	int cycles = 0;
	bit idle_on = 1;

	initial begin
		in_ch.valid = 0;
		in_ch.opcode = tss_pkg::OP_NONE;
		in_ch.from_literal = 0;
		in_ch.to_literal = 0;
		out_ch.ready = 0;
	end

	function automatic void mark_lit(input int lit);
		marks[lit] = 1'b1;
		if (trail_n < 64) begin
			trail[trail_n] = 6'(lit);
			trail_n++;
		end
		if (walk_n < 64) begin
			walk[walk_n] = 13'(lit);
			walk_n++;
		end
	endfunction

	function automatic bit closure_ok(input int lit);
		int v, k, j;
		if (marks[lit ^ 1]) return 0;
		if (marks[lit]) return 1;
		walk_n = 0;
		mark_lit(lit);
		while (walk_n > 0) begin
			v = walk[walk_n-1][5:0];
			k = walk[walk_n-1][12:6];
			j = 64;
			for (int i = k; i < 64; i++)
				if (graph[v][i]) begin
					j = i;
					break;
				end
			if (j >= 64) begin
				walk_n--;
				continue;
			end
			walk[walk_n-1] = {7'(j + 1), 6'(v)};
			if (marks[j ^ 1]) begin
				walk_n = 0;
				return 0;
			end
			if (!marks[j]) mark_lit(j);
		end
		return 1;
	endfunction

	function automatic bit solve_graph();
		int n, pos;
		n = nvars > tss_pkg::MaxVars ? tss_pkg::MaxVars : nvars;
		for (int v = 0; v < n; v++) begin
			pos = v * 2;
			if (marks[pos] || marks[pos+1]) continue;
			trail_n = 0;
			if (!closure_ok(pos)) begin
				while (trail_n > 0) begin
					trail_n--;
					marks[trail[trail_n]] = 1'b0;
				end
				if (!closure_ok(pos + 1)) return 0;
			end
		end
		return 1;
	endfunction

	task automatic predict(input logic [1:0] op, input logic [5:0] f, input logic [5:0] t);
		bit r;
		case (op)
			tss_pkg::OP_ADD: graph[f][t] = 1'b1;
			tss_pkg::OP_SOLVE: begin
				r = solve_graph();
				sat_q = {sat_q, r};
			end
			tss_pkg::OP_CLEAR: begin
				foreach (graph[i]) graph[i] = '0;
				marks = '0;
				trail_n = 0;
				walk_n = 0;
			end
			default: ;
		endcase
	endtask

	// valid stays high after a beat so the next beat can follow with no gap
	task automatic send_beat(input logic [1:0] op, input logic [5:0] f, input logic [5:0] t);
		if (idle_on && $urandom_range(99) < 26) begin
			in_ch.valid <= 0;
			@(posedge clk);
			while (idle_on && $urandom_range(99) < 26) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.opcode <= op;
		in_ch.from_literal <= f;
		in_ch.to_literal <= t;
		predict(op, f, t);
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (sat_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_vars(input int n);
		drain();
		cfg_we <= 1;
		cfg_wdata <= 6'(n);
		nvars = n & 63;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic add_clause(input int a, input int b);
		send_beat(tss_pkg::OP_ADD, 6'(a ^ 1), 6'(b));
		send_beat(tss_pkg::OP_ADD, 6'(b ^ 1), 6'(a));
	endtask

	always @(posedge clk) begin
		cycles++;
		out_ch.ready <= idle_on ? ($urandom_range(99) >= 26) : 1'b1;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (sat_q.size() == 0) begin
				$display("%0t: unexpected result satisfiable=%0d", $time, out_ch.satisfiable);
				errors++;
			end else begin
				if (out_ch.satisfiable !== sat_q[0]) begin
					$display("%0t: satisfiable expected %0d actual %0d", $time, sat_q[0],
						out_ch.satisfiable);
					errors++;
				end
				void'(sat_q.pop_front());
			end
		end
		if (cycles > 2000000) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic test_directed();
		set_vars(0);
		send_beat(tss_pkg::OP_SOLVE, 6'd0, 6'd0);
		set_vars(2);
		add_clause(0, 2);
		add_clause(1, 2);
		add_clause(0, 2);
		send_beat(tss_pkg::OP_SOLVE, 6'd63, 6'd63);
		send_beat(tss_pkg::OP_NONE, 6'd63, 6'd0);
		send_beat(tss_pkg::OP_CLEAR, 6'd0, 6'd0);
		set_vars(1);
		send_beat(tss_pkg::OP_ADD, 6'd0, 6'd1);
		send_beat(tss_pkg::OP_ADD, 6'd1, 6'd0);
		send_beat(tss_pkg::OP_SOLVE, 6'd0, 6'd0);
		send_beat(tss_pkg::OP_CLEAR, 6'd0, 6'd0);
		set_vars(63);
		send_beat(tss_pkg::OP_ADD, 6'd62, 6'd63);
		send_beat(tss_pkg::OP_ADD, 6'd63, 6'd0);
		send_beat(tss_pkg::OP_ADD, 6'd0, 6'd62);
		send_beat(tss_pkg::OP_SOLVE, 6'd0, 6'd0);
		send_beat(tss_pkg::OP_SOLVE, 6'd0, 6'd0);
		set_vars(32);
		send_beat(tss_pkg::OP_SOLVE, 6'd0, 6'd0);
		send_beat(tss_pkg::OP_CLEAR, 6'd0, 6'd0);
	endtask

	task automatic test_random();
		int n, m, r;
		for (int s = 0; s < 60; s++) begin
			if (s == 20) idle_on = 0;
			if (s == 30) idle_on = 1;
			r = $urandom_range(9);
			n = (r == 0) ? 32 + $urandom_range(31) : $urandom_range(1, 8);
			set_vars(n);
			send_beat(tss_pkg::OP_CLEAR, 6'($urandom), 6'($urandom));
			m = $urandom_range(2, 10);
			for (int i = 0; i < m; i++) begin
				if ($urandom_range(9) == 0)
					send_beat(2'($urandom), 6'($urandom), 6'($urandom));
				else
					add_clause($urandom_range(2 * (n > 32 ? 32 : n) - 1),
						$urandom_range(2 * (n > 32 ? 32 : n) - 1));
			end
			send_beat(tss_pkg::OP_SOLVE, 6'($urandom), 6'($urandom));
			if ($urandom_range(2) == 0)
				send_beat(tss_pkg::OP_SOLVE, 6'($urandom), 6'($urandom));
			if (s % 10 == 5) drain();
		end
	endtask

	initial begin
		foreach (graph[i]) graph[i] = '0;
		marks = '0;
		trail_n = 0;
		walk_n = 0;
		nvars = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		test_directed();
		test_random();
		drain();
		if (errors == 0) $display("tb_top OK");
		else $display("tb_top NOT OK");
		$finish;
	end
endmodule

// ===== files.f =====
design/tss_pkg.sv
design/tss_if.sv
design/tss_datapath.sv
design/tss_ctrl.sv
design/two_sat_solver_core.sv
tb/tb_top.sv
